// ===== hdl/sha256_hash_engine_core_defines.svh =====
// Assertion macros for the SHA-256 engine.
`ifndef SHA256_HASH_ENGINE_CORE_DEFINES_SVH
`define SHA256_HASH_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("sha256 check failed");
`define SHA_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("sha256 reset check failed");
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop)
`define SHA_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== hdl/sha256_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic start;   // load working regs from hash state
    logic run;     // perform one round
    logic fold;    // add working regs into hash state
    logic reinit;  // restore initial hash values
  } rnd_ctrl_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sha256_sched.sv =====
`timescale 1ns / 1ps
`default_nettype none
// 16-entry rolling message schedule; one word loaded or expanded per cycle.
module sha256_sched (
  input  wire logic        clk_i,
  input  wire logic        load_i,
  input  wire logic [3:0]  load_idx_i,
  input  wire logic [31:0] load_word_i,
  input  wire logic        step_i,
  input  wire logic [5:0]  round_i,
  output logic [31:0]      wt_o
);
  import sha256_pkg::*;

  logic [31:0] win_q [16];
  logic [3:0]  r0, r15, r2, r7;
  logic [31:0] w15, w2, sg0, sg1, wexp;

  always_comb begin
    r0   = round_i[3:0];
    r15  = r0 + 4'd1;
    r2   = r0 + 4'd14;
    r7   = r0 + 4'd9;
    w15  = win_q[r15];
    w2   = win_q[r2];
    sg0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    sg1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    wexp = win_q[r0] + sg0 + win_q[r7] + sg1;
    wt_o = (round_i < 6'd16) ? win_q[r0] : wexp;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      win_q[load_idx_i] <= load_word_i;
    end else if (step_i && round_i >= 6'd16) begin
      win_q[r0] <= wexp;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sha256_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared round datapath: working regs a..h and the eight hash words.
module sha256_round (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  sha256_pkg::rnd_ctrl_t      ctrl_i,
  input  wire logic [5:0]            round_i,
  input  wire logic [31:0]           wt_i,
  input  wire logic [2:0]            rd_idx_i,
  output logic [31:0]                hash_o
);
  import sha256_pkg::*;

  logic [31:0] wr_q [8];
  logic [31:0] hw_q [8];
  logic [31:0] s1, ch, t1, s0, mj;

  always_comb begin
    s1 = rotr(wr_q[4], 6) ^ rotr(wr_q[4], 11) ^ rotr(wr_q[4], 25);
    ch = (wr_q[4] & wr_q[5]) ^ (~wr_q[4] & wr_q[6]);
    t1 = wr_q[7] + s1 + ch + round_k(round_i) + wt_i;
    s0 = rotr(wr_q[0], 2) ^ rotr(wr_q[0], 13) ^ rotr(wr_q[0], 22);
    mj = (wr_q[0] & wr_q[1]) ^ (wr_q[0] & wr_q[2]) ^ (wr_q[1] & wr_q[2]);
    hash_o = hw_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        wr_q[i] <= '0;
        hw_q[i] <= init_hash(3'(i));
      end
    end else if (ctrl_i.reinit) begin
      for (int i = 0; i < 8; i++) hw_q[i] <= init_hash(3'(i));
    end else if (ctrl_i.start) begin
      for (int i = 0; i < 8; i++) wr_q[i] <= hw_q[i];
    end else if (ctrl_i.run) begin
      wr_q[7] <= wr_q[6];
      wr_q[6] <= wr_q[5];
      wr_q[5] <= wr_q[4];
      wr_q[4] <= wr_q[3] + t1;
      wr_q[3] <= wr_q[2];
      wr_q[2] <= wr_q[1];
      wr_q[1] <= wr_q[0];
      wr_q[0] <= t1 + s0 + mj;
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < 8; i++) hw_q[i] <= hw_q[i] + wr_q[i];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sha256_hash_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 engine. Message words arrive big-endian, one per input beat; the
// beat with last_i high ends the message and valid_bytes_i gives its byte
// count (values above 4 count as 4). A non-last word is taken in its beat;
// a word that completes a 16-word block is followed by a load, 64 rounds on
// the one shared round unit and a fold, and no word is taken meanwhile. The
// last word runs padding (one pad word per cycle outside rounds, up to two
// blocks), then eight digest beats, index 0 first, final_res_o on index 7.
// The input stalls throughout. The hash state restarts for the next message.
`include "sha256_hash_engine_core_defines.svh"
module sha256_hash_engine_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  valid_bytes_i,
  input  wire logic        last_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             final_res_o
);
  import sha256_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_PAD = 3'd4;
  localparam logic [2:0] ST_OUT = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [3:0]  wib_q, wib_d;        // words in block
  logic [63:0] bytes_q, bytes_d;
  logic [5:0]  round_q, round_d;
  logic        padding_q, padding_d; // in the padding tail of a message
  logic        tail80_q, tail80_d;   // 0x80 word still owed (full last word)
  logic [2:0]  oidx_q, oidx_d;
  logic        bits_done_q, bits_done_d; // high length word is in this block
  logic        load;
  logic [31:0] load_word, wt, hash, keep;
  logic [63:0] bits;
  logic [2:0]  nb;
  rnd_ctrl_t   ctrl;

  sha256_sched u_sched (
    .clk_i, .load_i(load), .load_idx_i(wib_q), .load_word_i(load_word),
    .step_i(ctrl.run), .round_i(round_q), .wt_o(wt)
  );

  sha256_round u_round (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .round_i(round_q), .wt_i(wt),
    .rd_idx_i(oidx_q), .hash_o(hash)
  );

  assign stall_o       = (state_q != ST_IDLE);
  assign valid_o       = (state_q == ST_OUT);
  assign digest_word_o = hash;
  assign word_index_o  = oidx_q;
  assign final_res_o   = (oidx_q == 3'd7);

  always_comb begin
    nb   = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
    keep = (nb == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {nb, 3'b000}));
    bits = {bytes_q[60:0], 3'b000};
    state_d = state_q; wib_d = wib_q; bytes_d = bytes_q; round_d = round_q;
    padding_d = padding_q; tail80_d = tail80_q; oidx_d = oidx_q;
    load = 1'b0; load_word = '0; ctrl = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          load = 1'b1;
          wib_d = wib_q + 4'd1;
          if (!last_i) begin
            load_word = data_word_i;
            bytes_d = bytes_q + 64'd4;
          end else begin
            bytes_d = bytes_q + 64'(nb);
            padding_d = 1'b1;
            if (nb == 3'd4) begin
              load_word = data_word_i;
              tail80_d = 1'b1;
            end else begin
              load_word = (data_word_i & keep) | (32'h80000000 >> {nb, 3'b000});
            end
          end
          if (wib_q == 4'd15) state_d = ST_START;
          else if (last_i) state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        load = 1'b1;
        wib_d = wib_q + 4'd1;
        if (tail80_q) begin
          load_word = 32'h80000000;
          tail80_d = 1'b0;
        end else if (wib_q == 4'd14) begin
          load_word = bits[63:32];
        end else if (wib_q == 4'd15 && bits_done_q) begin
          load_word = bits[31:0];
        end else begin
          // slot 15 stays zero when the length has to go in the next block
          load_word = '0;
        end
        if (wib_q == 4'd15) state_d = ST_START;
      end
      ST_START: begin
        ctrl.start = 1'b1;
        round_d = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        ctrl.run = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        ctrl.fold = 1'b1;
        round_d = '0;
        // length words sit in slots 14/15 only when the tail is done
        if (padding_q && !tail80_q && bits_done_q) begin
          state_d = ST_OUT;
          oidx_d = '0;
        end else if (padding_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!stall_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            ctrl.reinit = 1'b1;
            state_d = ST_IDLE;
            bytes_d = '0;
            padding_d = 1'b0;
            wib_d = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Set when the high length word was loaded into the block being filled.
  always_comb begin
    bits_done_d = bits_done_q;
    if (state_q == ST_PAD && !tail80_q && wib_q == 4'd14) bits_done_d = 1'b1;
    else if (state_q == ST_IDLE) bits_done_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wib_q <= '0;
      bytes_q <= '0;
      round_q <= '0;
      padding_q <= 1'b0;
      tail80_q <= 1'b0;
      oidx_q <= '0;
      bits_done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wib_q <= wib_d;
      bytes_q <= bytes_d;
      round_q <= round_d;
      padding_q <= padding_d;
      tail80_q <= tail80_d;
      oidx_q <= oidx_d;
      bits_done_q <= bits_done_d;
    end
  end

  `SHA_ASSERT(a_no_out_idle, clk_i, rst_ni, valid_o |-> stall_o)
  `SHA_ASSERT(a_round_wrap, clk_i, rst_ni, (state_q == ST_ROUND && round_q == 6'd63) |=> state_q == ST_FOLD)
  `SHA_ASSERT(a_out_done, clk_i, rst_ni, (valid_o && !stall_i && final_res_o) |=> !valid_o && wib_q == 4'd0)
  `SHA_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |=> !valid_o)
endmodule
`default_nettype wire
